### rtl/pabl_pkg.sv
// Shared constants, calibration tables and types for the PA drive bilinear lookup.
// Depends on nothing; every other file of the block depends on it.
package pabl_pkg;

  localparam int FREQ_POINTS  = 9;
  localparam int POWER_POINTS = 8;

  localparam int FREQ_W  = 16;
  localparam int DBM_W   = 8;
  localparam int DRIVE_W = 12;
  localparam int ROM_W   = 10;
  localparam int ROW_W   = $clog2(POWER_POINTS);
  localparam int COL_W   = $clog2(FREQ_POINTS);
  localparam int DX_W    = 3;
  localparam int DY_W    = 6;
  localparam int A_W     = ROM_W + DX_W + 1;
  localparam int NUM_W   = A_W + DY_W + 1;
  localparam int RCP_K   = 30;
  localparam int RCP_W   = 24;
  localparam int PROD_W  = NUM_W + RCP_W;

  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_FULL_DRIVE = 1'b0;

  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 12'd1500;
  localparam logic [DBM_W-1:0]   LOW_DBM     = 8'd10;
  localparam logic [DBM_W-1:0]   HIGH_DBM    = 8'd26;

  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_FULL   = 2'd1;
  localparam logic [1:0] MODE_INTERP = 2'd2;

  localparam logic [DBM_W-1:0] DBM_AXIS [POWER_POINTS] =
    '{8'd10, 8'd14, 8'd16, 8'd20, 8'd23, 8'd26, 8'd29, 8'd32};

  localparam logic [FREQ_W-1:0] FREQ_AXIS [FREQ_POINTS] =
    '{16'd5600, 16'd5650, 16'd5700, 16'd5750, 16'd5800,
      16'd5850, 16'd5900, 16'd5950, 16'd6000};

  localparam logic [ROM_W-1:0] DRIVE_ROM [POWER_POINTS][FREQ_POINTS] = '{
    '{10'd415, 10'd375, 10'd375, 10'd380, 10'd380, 10'd380, 10'd395, 10'd390, 10'd400},
    '{10'd420, 10'd420, 10'd400, 10'd400, 10'd405, 10'd425, 10'd430, 10'd440, 10'd435},
    '{10'd470, 10'd455, 10'd445, 10'd445, 10'd455, 10'd465, 10'd485, 10'd490, 10'd490},
    '{10'd525, 10'd510, 10'd490, 10'd490, 10'd500, 10'd515, 10'd540, 10'd550, 10'd545},
    '{10'd575, 10'd565, 10'd555, 10'd545, 10'd560, 10'd575, 10'd595, 10'd600, 10'd600},
    '{10'd640, 10'd630, 10'd610, 10'd610, 10'd625, 10'd645, 10'd665, 10'd675, 10'd670},
    '{10'd730, 10'd710, 10'd685, 10'd680, 10'd690, 10'd725, 10'd750, 10'd755, 10'd755},
    '{10'd805, 10'd785, 10'd755, 10'd755, 10'd770, 10'd805, 10'd830, 10'd840, 10'd835}
  };

  // The frequency axis is evenly spaced, so each cell's area depends on the power row only.
  localparam longint FREQ_STEP = longint'(FREQ_AXIS[1]) - longint'(FREQ_AXIS[0]);

  localparam longint DEN_TAB [POWER_POINTS-1] = '{
    (longint'(DBM_AXIS[1]) - longint'(DBM_AXIS[0])) * FREQ_STEP,
    (longint'(DBM_AXIS[2]) - longint'(DBM_AXIS[1])) * FREQ_STEP,
    (longint'(DBM_AXIS[3]) - longint'(DBM_AXIS[2])) * FREQ_STEP,
    (longint'(DBM_AXIS[4]) - longint'(DBM_AXIS[3])) * FREQ_STEP,
    (longint'(DBM_AXIS[5]) - longint'(DBM_AXIS[4])) * FREQ_STEP,
    (longint'(DBM_AXIS[6]) - longint'(DBM_AXIS[5])) * FREQ_STEP,
    (longint'(DBM_AXIS[7]) - longint'(DBM_AXIS[6])) * FREQ_STEP
  };

  // Rounded-up reciprocals; exact for numerators below 2**(RCP_K - 8).
  localparam logic [RCP_W-1:0] RCP_TAB [POWER_POINTS-1] = '{
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[0] - 1) / DEN_TAB[0]),
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[1] - 1) / DEN_TAB[1]),
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[2] - 1) / DEN_TAB[2]),
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[3] - 1) / DEN_TAB[3]),
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[4] - 1) / DEN_TAB[4]),
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[5] - 1) / DEN_TAB[5]),
    RCP_W'(((longint'(1) << RCP_K) + DEN_TAB[6] - 1) / DEN_TAB[6])
  };

  typedef struct packed {
    logic [1:0] mode;
    logic       carrier_off;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [DX_W-1:0]  wx_lo;
    logic [DX_W-1:0]  wx_hi;
    logic [DY_W-1:0]  wy_lo;
    logic [DY_W-1:0]  wy_hi;
    logic [RCP_W-1:0] recip;
  } req_t;

  typedef struct packed {
    logic [ROM_W-1:0] q00;
    logic [ROM_W-1:0] q01;
    logic [ROM_W-1:0] q10;
    logic [ROM_W-1:0] q11;
  } corner_t;

endpackage

### rtl/pabl_rom.sv
// Calibration ROM with a registered read of the four corners of one cell.
// Depends on pabl_pkg for the table and the corner type.
module pabl_rom (
  input  logic                     clk,
  input  logic                     en,
  input  logic [pabl_pkg::ROW_W-1:0] row,
  input  logic [pabl_pkg::COL_W-1:0] col,
  output pabl_pkg::corner_t        corner
);
  import pabl_pkg::*;

  logic [ROW_W-1:0] row_up;
  logic [COL_W-1:0] col_up;
  corner_t          corner_r;

  assign row_up = row + ROW_W'(1);
  assign col_up = col + COL_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      corner_r.q00 <= DRIVE_ROM[row][col];
      corner_r.q01 <= DRIVE_ROM[row][col_up];
      corner_r.q10 <= DRIVE_ROM[row_up][col];
      corner_r.q11 <= DRIVE_ROM[row_up][col_up];
    end
  end

  assign corner = corner_r;

endmodule

### rtl/pabl_pipe.sv
// Interpolation pipeline: power blend, frequency blend, reciprocal divide, output register.
// Depends on pabl_pkg for widths, mode codes and the request and corner types.
module pabl_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        v1,
  input  pabl_pkg::req_t              req,
  input  pabl_pkg::corner_t           corner,
  input  logic [pabl_pkg::DRIVE_W-1:0] full_drive,
  output logic                        rdy1,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pabl_pkg::DRIVE_W-1:0] out_drive_value,
  output logic                        out_carrier_off
);
  import pabl_pkg::*;

  logic rdy2, rdy3, rdy4, rdy_o;
  logic v2_r, v3_r, v4_r, ov_r;

  tag_t             tag2_r, tag3_r, tag4_r;
  logic [A_W-1:0]   a2_r, b2_r, a_nxt, b_nxt;
  logic [DY_W-1:0]  wy_lo2_r, wy_hi2_r;
  logic [RCP_W-1:0] rcp2_r, rcp3_r;
  logic [NUM_W-1:0] num3_r, num_nxt;
  logic [PROD_W-1:0] prod4_r, prod_nxt;
  logic [DRIVE_W-1:0] drive_nxt, drive_r;
  logic             coff_r;

  assign rdy_o = !ov_r || !out_stall;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1 || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= v1;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy_o) ov_r <= v4_r;
    end
  end

  assign a_nxt = A_W'(corner.q00) * A_W'(req.wx_lo) + A_W'(corner.q10) * A_W'(req.wx_hi);
  assign b_nxt = A_W'(corner.q01) * A_W'(req.wx_lo) + A_W'(corner.q11) * A_W'(req.wx_hi);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      tag2_r   <= req.tag;
      a2_r     <= a_nxt;
      b2_r     <= b_nxt;
      wy_lo2_r <= req.wy_lo;
      wy_hi2_r <= req.wy_hi;
      rcp2_r   <= req.recip;
    end
  end

  assign num_nxt = NUM_W'(a2_r) * NUM_W'(wy_lo2_r) + NUM_W'(b2_r) * NUM_W'(wy_hi2_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      tag3_r <= tag2_r;
      num3_r <= num_nxt;
      rcp3_r <= rcp2_r;
    end
  end

  assign prod_nxt = PROD_W'(num3_r) * PROD_W'(rcp3_r);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      tag4_r  <= tag3_r;
      prod4_r <= prod_nxt;
    end
  end

  always_comb begin
    unique case (tag4_r.mode)
      MODE_ZERO:   drive_nxt = '0;
      MODE_FULL:   drive_nxt = full_drive;
      MODE_INTERP: drive_nxt = prod4_r[RCP_K +: DRIVE_W];
      default:     drive_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      drive_r <= drive_nxt;
      coff_r  <= tag4_r.carrier_off;
    end
  end

  assign out_valid       = ov_r;
  assign out_drive_value = drive_r;
  assign out_carrier_off = coff_r;

endmodule

### rtl/pa_drive_bilinear_lookup_top.sv
// Top level of the PA drive bilinear lookup: configuration port, segment search, pipeline.
// Depends on pabl_pkg, pabl_rom and pabl_pipe.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   in_freq_mhz[15:0], in_power_dbm[7:0]
//   out      output     out_valid / out_stall out_drive_value[11:0], out_carrier_off
//   cfg      input      APB write and read    full_drive_value at byte address 0
//
// One request is accepted per clock while in_stall is low; its result shows on out_valid after
// passing the segment and ROM stage, two blend multiplies, the reciprocal multiply and the
// output register. Reset clears all valid flags and sets the full drive value to 1500. An
// out_stall holds the result, and in_stall rises only once every stage is occupied.
module pa_drive_bilinear_lookup_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pabl_pkg::FREQ_W-1:0]    in_freq_mhz,
  input  logic [pabl_pkg::DBM_W-1:0]     in_power_dbm,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pabl_pkg::DRIVE_W-1:0]   out_drive_value,
  output logic                           out_carrier_off,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pabl_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [pabl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pabl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import pabl_pkg::*;

  logic [DRIVE_W-1:0] full_drive_r;
  logic               rdy1;
  logic               v1_r;
  req_t               req_r, req_nxt;
  corner_t            corner;

  logic [FREQ_W-1:0]  y, y1, y2;
  logic [DBM_W-1:0]   x, x1, x2;
  logic [ROW_W-1:0]   p;
  logic [COL_W-1:0]   f;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FULL_DRIVE) ? CFG_DATA_W'(full_drive_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_drive_r <= DRIVE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_FULL_DRIVE) begin
      full_drive_r <= cfg_pwdata[DRIVE_W-1:0];
    end
  end

  always_comb begin
    y = in_freq_mhz;
    if (y < FREQ_AXIS[0]) y = FREQ_AXIS[0];
    if (y > FREQ_AXIS[FREQ_POINTS-1]) y = FREQ_AXIS[FREQ_POINTS-1];
    x = in_power_dbm;
    if (x < DBM_AXIS[0]) x = DBM_AXIS[0];
    if (x > DBM_AXIS[POWER_POINTS-1]) x = DBM_AXIS[POWER_POINTS-1];

    p = ROW_W'(POWER_POINTS - 2);
    for (int i = POWER_POINTS - 3; i >= 0; i--) begin
      if (x < DBM_AXIS[i+1]) p = ROW_W'(i);
    end
    f = COL_W'(FREQ_POINTS - 2);
    for (int j = FREQ_POINTS - 3; j >= 0; j--) begin
      if (y < FREQ_AXIS[j+1]) f = COL_W'(j);
    end

    x1 = DBM_AXIS[p];
    x2 = DBM_AXIS[p + ROW_W'(1)];
    y1 = FREQ_AXIS[f];
    y2 = FREQ_AXIS[f + COL_W'(1)];

    req_nxt.wx_lo = DX_W'(x2 - x);
    req_nxt.wx_hi = DX_W'(x - x1);
    req_nxt.wy_lo = DY_W'(y2 - y);
    req_nxt.wy_hi = DY_W'(y - y1);
    req_nxt.recip = RCP_TAB[p];
    req_nxt.tag.carrier_off = (in_power_dbm == '0);
    priority if (in_power_dbm < LOW_DBM) begin
      req_nxt.tag.mode = MODE_ZERO;
    end else if (in_power_dbm >= HIGH_DBM) begin
      req_nxt.tag.mode = MODE_FULL;
    end else begin
      req_nxt.tag.mode = MODE_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      req_r <= req_nxt;
    end
  end

  assign in_stall = !rdy1;

  pabl_rom u_rom (
    .clk    (clk),
    .en     (rdy1),
    .row    (p),
    .col    (f),
    .corner (corner)
  );

  pabl_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .v1              (v1_r),
    .req             (req_r),
    .corner          (corner),
    .full_drive      (full_drive_r),
    .rdy1            (rdy1),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_value (out_drive_value),
    .out_carrier_off (out_carrier_off)
  );

endmodule

### rtl/pabl_chk.sv
// Port-level checks for the PA drive bilinear lookup, attached to the top level by bind.
// Depends on pabl_pkg for the drive width.
module pabl_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pabl_pkg::DRIVE_W-1:0] out_drive_value,
  input logic                         out_carrier_off
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_value)
      && $stable(out_carrier_off))
    else $error("Stalled result changed or vanished.");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carrier_off |-> out_drive_value == '0)
    else $error("Carrier-off result carries a nonzero drive.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output side is free.");

endmodule

bind pa_drive_bilinear_lookup_top pabl_chk u_pabl_chk (.*);
